// File: rtl/bottom_k_count_sketch_top_defines.svh
// ----------------------------------------------------------------------------
// Bottom-k count sketch assertion macros
// Property shorthands for the checker file of the sketch block.
// ----------------------------------------------------------------------------
`ifndef BOTTOM_K_COUNT_SKETCH_TOP_DEFINES_SVH
`define BOTTOM_K_COUNT_SKETCH_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, idle during reset.
`define BKS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sketch check failed");

// Next-cycle implication, sampled on clk, idle during reset.
`define BKS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sketch check failed");

`endif

// File: rtl/bks_pkg.sv
// ----------------------------------------------------------------------------
// Bottom-k count sketch package
// Sizes, codes and transfer types shared by the sketch modules.
// ----------------------------------------------------------------------------
package bks_pkg;

  localparam int SKETCH_SIZE = 64;
  localparam int COUNT_BITS  = 32;
  localparam int HASH_W      = 64;
  localparam int IDX_W       = 6;
  localparam int ENTRIES_W   = 7;
  localparam int OUT_CNT_W   = 32;
  localparam int HALF_W      = 32;
  // A 64-bit value divided by the prime gives a quotient below 2^21.
  localparam int QUOT_W      = 21;
  localparam int PROD_W      = HALF_W + QUOT_W;

  localparam logic [HASH_W-1:0] HASH_PRIME = 64'd9999999999971;
  localparam logic [HASH_W-1:0] PRIME_X2   = HASH_PRIME << 1;
  // The prime split into its upper and lower halves.
  localparam logic [HALF_W-1:0] PRIME_HI   = HASH_PRIME[HASH_W-1:HALF_W];
  localparam logic [HALF_W-1:0] PRIME_LO   = HASH_PRIME[HALF_W-1:0];
  // Truncated reciprocal: floor(2^64 / prime). The prime does not divide
  // 2^64, so dividing the all-ones value gives the same figure.
  localparam logic [QUOT_W-1:0] PRIME_RECIP = QUOT_W'(64'hFFFF_FFFF_FFFF_FFFF / HASH_PRIME);

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [1:0] ST_DISCARD = 2'd0;
  localparam logic [1:0] ST_INSERT  = 2'd1;
  localparam logic [1:0] ST_INCR    = 2'd2;
  localparam logic [1:0] ST_READ    = 2'd3;

  localparam logic REG_ENTRIES = 1'b0;
  localparam logic REG_BOTH    = 1'b1;

  typedef struct packed {
    logic              command;
    logic [HASH_W-1:0] forward_hash;
    logic [HASH_W-1:0] reverse_hash;
    logic [IDX_W-1:0]  read_index;
  } bks_in_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [IDX_W-1:0]     position;
    logic [HASH_W-1:0]    hash_value;
    logic [OUT_CNT_W-1:0] count;
  } bks_out_t;

  // State handed from one cell to the next.
  typedef struct packed {
    logic [HASH_W-1:0]     hash;
    logic [COUNT_BITS-1:0] count;
    logic                  ge;
  } bks_link_t;

  // Control broadcast to every cell.
  typedef struct packed {
    logic cmp;
    logic upd;
    logic hit;
  } bks_ctrl_t;

  // What a cell reports back after the compare phase.
  typedef struct packed {
    logic                  first;
    logic                  eq_first;
    logic [COUNT_BITS-1:0] count_inc;
  } bks_stat_t;

endpackage

// File: rtl/bks_mod.sv
// ----------------------------------------------------------------------------
// Bottom-k count sketch modulo unit
// Reduces a 64-bit hash modulo the fixed prime.
// ----------------------------------------------------------------------------
module bks_mod
  import bks_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  logic [HASH_W-1:0] value,
  output logic              done,
  output logic [HASH_W-1:0] result
);

  logic [HASH_W-1:0] value_r;
  logic [QUOT_W-1:0] quot_r, quot_nxt;
  logic [HALF_W-1:0] prod_hi_r, prod_hi_nxt;
  logic [PROD_W-1:0] prod_lo_r, prod_lo_nxt;
  logic [HASH_W-1:0] rem_r, rem_nxt, fix_nxt;
  logic [3:0]        stage_r;
  logic              done_r;
  logic [PROD_W-1:0] recip_prod;

  // The quotient estimate uses only the upper half of the value and a
  // truncated reciprocal, so it can fall short by up to two. The remainder
  // taken from it is then below three times the prime, and one compare
  // against the prime and its double settles it.
  always_comb begin
    recip_prod  = PROD_W'(value_r[HASH_W-1:HALF_W]) * PROD_W'(PRIME_RECIP);
    quot_nxt    = recip_prod[PROD_W-1:HALF_W];
    prod_hi_nxt = HALF_W'(quot_r * PRIME_HI);
    prod_lo_nxt = PROD_W'(quot_r) * PROD_W'(PRIME_LO);
    rem_nxt     = value_r - {prod_hi_r, HALF_W'(0)} - HASH_W'(prod_lo_r);
    if (rem_r >= PRIME_X2) begin
      fix_nxt = rem_r - PRIME_X2;
    end else if (rem_r >= HASH_PRIME) begin
      fix_nxt = rem_r - HASH_PRIME;
    end else begin
      fix_nxt = rem_r;
    end
  end

  // One-hot progress: quotient, partial products, remainder, correction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= '0;
      done_r  <= 1'b0;
    end else if (load) begin
      stage_r <= 4'b0001;
      done_r  <= 1'b0;
    end else begin
      stage_r <= stage_r << 1;
      if (stage_r[3]) begin
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      value_r <= value;
    end
    if (stage_r[0]) begin
      quot_r <= quot_nxt;
    end
    if (stage_r[1]) begin
      prod_hi_r <= prod_hi_nxt;
      prod_lo_r <= prod_lo_nxt;
    end
    if (stage_r[2]) begin
      rem_r <= rem_nxt;
    end else if (stage_r[3]) begin
      rem_r <= fix_nxt;
    end
  end

  assign done   = done_r;
  assign result = rem_r;

endmodule

// File: rtl/bks_cell.sv
// ----------------------------------------------------------------------------
// Bottom-k count sketch cell
// Holds one sketch position and shifts its contents to the next cell on insert.
// ----------------------------------------------------------------------------
module bks_cell
  import bks_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  bks_ctrl_t         ctrl,
  input  logic [HASH_W-1:0] key,
  input  logic              active,
  input  bks_link_t         prev,
  output bks_link_t         link,
  output bks_stat_t         stat
);

  logic [HASH_W-1:0]     hash_r;
  logic [COUNT_BITS-1:0] count_r;
  logic                  ge_r, eq_r;
  logic                  first;
  logic [COUNT_BITS-1:0] count_inc;

  // The sketch stays sorted, so the ge flags form a run of ones up to the end
  // of the active part; the first one marks the target position.
  assign first     = ge_r & ~prev.ge;
  assign count_inc = (count_r == '1) ? count_r : count_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r  <= '1;
      count_r <= '0;
      ge_r    <= 1'b0;
      eq_r    <= 1'b0;
    end else if (ctrl.cmp) begin
      ge_r <= active & (hash_r >= key);
      eq_r <= hash_r == key;
    end else if (ctrl.upd) begin
      if (ctrl.hit) begin
        if (first && eq_r) begin
          count_r <= count_inc;
        end
      end else if (first) begin
        hash_r  <= key;
        count_r <= COUNT_BITS'(1);
      end else if (ge_r) begin
        hash_r  <= prev.hash;
        count_r <= prev.count;
      end
    end
  end

  assign link.hash  = hash_r;
  assign link.count = count_r;
  assign link.ge    = ge_r;

  assign stat.first     = first;
  assign stat.eq_first  = first & eq_r;
  assign stat.count_inc = first ? count_inc : '0;

endmodule

// File: rtl/bottom_k_count_sketch_top.sv
// ----------------------------------------------------------------------------
// Bottom-k count sketch
// Keeps the smallest distinct reduced hashes in sorted order with counts.
// ----------------------------------------------------------------------------
// Usage. An item is transferred at a rising edge with start high and busy low.
// An add item (command 0) picks the forward hash, or the smaller of forward
// and reverse-complement hashes when both_strands is set, reduces it modulo
// the fixed prime and then updates a row of 64 cells: a match increments its
// saturating count, a smaller value is inserted and larger entries move one
// cell up, anything else is discarded. A read item (command 1) returns the
// entry at read_index.
// Each item yields exactly one result, shown on out_data for one cycle with
// out_valid high. A read result appears in the cycle after the transfer and
// busy stays low, so reads may follow each other every cycle. An add holds
// busy while it passes through the modulo unit (quotient estimate, partial
// products, remainder, final correction), a state that takes its result, a
// state in which the cells compare and one in which they shift or count;
// its result appears once busy is low again, and the next item can be
// transferred from then on. Configuration must be written by the user
// through cfg_we, cfg_index and cfg_wdata only while the block is idle;
// the block itself does not enforce this. Synchronous reset empties every
// cell (hash all ones, count zero), sets sketch_entries to 64 and clears
// both_strands. The receiver cannot stall, so no result is ever held back.
// ----------------------------------------------------------------------------
module bottom_k_count_sketch_top
  import bks_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  bks_in_t              in_data,
  output logic                 out_valid,
  output bks_out_t             out_data,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [ENTRIES_W-1:0] cfg_wdata
);

  typedef enum logic [1:0] {S_IDLE, S_MOD, S_CMP, S_UPD} state_t;

  state_t               state_r;
  logic [ENTRIES_W-1:0] entries_r;
  logic                 both_r;
  logic                 out_valid_r;
  bks_out_t             out_data_r;

  logic                 accept;
  logic [HASH_W-1:0]    chosen;
  logic                 mod_done;
  logic [HASH_W-1:0]    key;
  logic [ENTRIES_W-1:0] active_len;
  logic [IDX_W:0]       rd_slot;
  bks_ctrl_t            ctrl;

  bks_link_t            links [SKETCH_SIZE+1];
  bks_stat_t            stats [SKETCH_SIZE];

  logic                  any_first, any_eq;
  logic [IDX_W-1:0]      hit_pos;
  logic [COUNT_BITS-1:0] hit_count;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = state_r != S_IDLE;

  // Strand choice ahead of the reduction.
  assign chosen = (both_r && (in_data.reverse_hash < in_data.forward_hash))
                  ? in_data.reverse_hash : in_data.forward_hash;

  // A length of zero behaves as one; lengths above the store are clipped.
  always_comb begin
    if (entries_r == '0) begin
      active_len = ENTRIES_W'(1);
    end else if (entries_r > ENTRIES_W'(SKETCH_SIZE)) begin
      active_len = ENTRIES_W'(SKETCH_SIZE);
    end else begin
      active_len = entries_r;
    end
  end

  // Cell i drives link i+1; the sum is one bit wider so the last cell is reached.
  assign rd_slot = {1'b0, in_data.read_index} + (IDX_W+1)'(1);

  bks_mod u_mod (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (accept && (in_data.command == CMD_ADD)),
    .value  (chosen),
    .done   (mod_done),
    .result (key)
  );

  assign ctrl.cmp = state_r == S_CMP;
  assign ctrl.upd = state_r == S_UPD;
  assign ctrl.hit = any_eq;

  // The chain head: nothing sits in front of the first cell.
  assign links[0] = '{hash: '1, count: '0, ge: 1'b0};

  for (genvar g = 0; g < SKETCH_SIZE; g++) begin : g_cell
    bks_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctrl   (ctrl),
      .key    (key),
      .active (ENTRIES_W'(g) < active_len),
      .prev   (links[g]),
      .link   (links[g+1]),
      .stat   (stats[g])
    );
  end

  // At most one cell reports the first position, so plain OR trees collect it.
  always_comb begin
    any_first = 1'b0;
    any_eq    = 1'b0;
    hit_pos   = '0;
    hit_count = '0;
    for (int i = 0; i < SKETCH_SIZE; i++) begin
      any_first = any_first | stats[i].first;
      any_eq    = any_eq | stats[i].eq_first;
      hit_pos   = hit_pos | (stats[i].first ? IDX_W'(i) : '0);
      hit_count = hit_count | stats[i].count_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      entries_r   <= ENTRIES_W'(SKETCH_SIZE);
      both_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          REG_ENTRIES: entries_r <= cfg_wdata;
          REG_BOTH:    both_r    <= cfg_wdata[0];
          default:     ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (in_data.command == CMD_READ) begin
              out_valid_r <= 1'b1;
              out_data_r  <= '{status:     ST_READ,
                               position:   in_data.read_index,
                               hash_value: links[rd_slot].hash,
                               count:      OUT_CNT_W'(links[rd_slot].count)};
            end else begin
              state_r <= S_MOD;
            end
          end
        end
        S_MOD: begin
          if (mod_done) begin
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          state_r <= S_UPD;
        end
        S_UPD: begin
          state_r     <= S_IDLE;
          out_valid_r <= 1'b1;
          if (!any_first) begin
            out_data_r <= '{status: ST_DISCARD, position: '0, hash_value: key, count: '0};
          end else if (any_eq) begin
            out_data_r <= '{status: ST_INCR, position: hit_pos, hash_value: key,
                            count: OUT_CNT_W'(hit_count)};
          end else begin
            out_data_r <= '{status: ST_INSERT, position: hit_pos, hash_value: key,
                            count: OUT_CNT_W'(1)};
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/bks_checker.sv
// ----------------------------------------------------------------------------
// Bottom-k count sketch checker
// Port-level properties of the sketch, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "bottom_k_count_sketch_top_defines.svh"

module bks_checker
  import bks_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input bks_in_t  in_data,
  input logic     out_valid,
  input bks_out_t out_data
);

  // A read is answered in the very next cycle.
  `BKS_ASSERT_NXT(a_read_next, start && !busy && (in_data.command == CMD_READ), out_valid && (out_data.status == ST_READ))
  // An add that is taken raises busy.
  `BKS_ASSERT_NXT(a_add_busy, start && !busy && (in_data.command == CMD_ADD), busy)
  // Add results only close a busy period.
  `BKS_ASSERT_IMP(a_add_end, out_valid && (out_data.status != ST_READ), $past(busy) && !busy)
  // A fresh entry always starts at a count of one.
  `BKS_ASSERT_IMP(a_insert_one, out_valid && (out_data.status == ST_INSERT), out_data.count == OUT_CNT_W'(1))

endmodule

bind bottom_k_count_sketch_top bks_checker u_bks_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bottom-k count sketch testbench
// Drives add and read commands into the sketch under several register
// settings and idling patterns. A shadow copy of the sorted hash store
// predicts every result, and each result is checked field by field in order.
// ----------------------------------------------------------------------------
module testbench;
  import bks_pkg::*;

  localparam int PHASE_ITEMS = 117;  // six random phases, about 700 items
  localparam int READ_PCT    = 20;   // share of read commands in random traffic
  localparam int POOL_DEPTH  = 16;   // recent raw hashes kept for reuse
  localparam int TAIL_CYCLES = 30;   // quiet cycles at the end, after all results are in

  // Shadow of the sketch: sorted hashes, counts and the two registers, plus
  // the results still owed by the block in transfer order.
  class sketch_mirror;
    logic [HASH_W-1:0]     kept_hash [SKETCH_SIZE];
    logic [COUNT_BITS-1:0] kept_count[SKETCH_SIZE];
    logic [ENTRIES_W-1:0]  entries_reg;
    logic                  both_reg;
    bks_out_t              owed_results[$];
    int unsigned           failures;

    function new();
      for (int j = 0; j < SKETCH_SIZE; j++) begin
        kept_hash[j]  = '1;
        kept_count[j] = '0;
      end
      entries_reg = ENTRIES_W'(SKETCH_SIZE);
      both_reg    = 1'b0;
      failures    = 0;
    endfunction

    function void write_register(logic idx, logic [ENTRIES_W-1:0] value);
      if (idx == REG_ENTRIES) begin
        entries_reg = value;
      end else begin
        both_reg = value[0];
      end
    endfunction

    // Applies one accepted command to the shadow store and queues its result.
    function void note_item(bks_in_t item);
      bks_out_t          r;
      logic [HASH_W-1:0] chosen;
      logic [HASH_W-1:0] reduced;
      int                n;
      int                pos;
      if (item.command == CMD_READ) begin
        r.status     = ST_READ;
        r.position   = item.read_index;
        r.hash_value = kept_hash[item.read_index];
        r.count      = OUT_CNT_W'(kept_count[item.read_index]);
      end else begin
        chosen = item.forward_hash;
        if (both_reg && item.reverse_hash < item.forward_hash) chosen = item.reverse_hash;
        reduced = chosen % HASH_PRIME;
        // A length of zero behaves as one, anything past the store as the store.
        if (entries_reg == 0) n = 1;
        else if (entries_reg > SKETCH_SIZE) n = SKETCH_SIZE;
        else n = int'(entries_reg);
        pos = n;
        for (int j = 0; j < n; j++) begin
          if (kept_hash[j] >= reduced) begin
            pos = j;
            break;
          end
        end
        r.hash_value = reduced;
        if (pos >= n) begin
          r.status   = ST_DISCARD;
          r.position = '0;
          r.count    = '0;
        end else if (kept_hash[pos] == reduced) begin
          if (kept_count[pos] != '1) kept_count[pos] = kept_count[pos] + 1'b1;
          r.status   = ST_INCR;
          r.position = IDX_W'(pos);
          r.count    = OUT_CNT_W'(kept_count[pos]);
        end else begin
          for (int j = n - 1; j > pos; j--) begin
            kept_hash[j]  = kept_hash[j-1];
            kept_count[j] = kept_count[j-1];
          end
          kept_hash[pos]  = reduced;
          kept_count[pos] = 1;
          r.status   = ST_INSERT;
          r.position = IDX_W'(pos);
          r.count    = 1;
        end
      end
      owed_results = {owed_results, r};
    endfunction

    function void report_field(string field, logic [HASH_W-1:0] want,
                               logic [HASH_W-1:0] seen);
      if (want !== seen) begin
        failures++;
        $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, seen);
      end
    endfunction

    function void check_reply(bks_out_t got);
      bks_out_t want;
      if (owed_results.size() == 0) begin
        failures++;
        $error("result with no command outstanding: status %0d position %0d",
               got.status, got.position);
        return;
      end
      want = owed_results.pop_front();
      report_field("status", HASH_W'(want.status), HASH_W'(got.status));
      report_field("position", HASH_W'(want.position), HASH_W'(got.position));
      report_field("hash_value", want.hash_value, got.hash_value);
      report_field("count", HASH_W'(want.count), HASH_W'(got.count));
    endfunction

    function int unsigned pending();
      return owed_results.size();
    endfunction
  endclass

  // Every input holds a known value from time zero.
  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 start     = 1'b0;
  bks_in_t              in_data   = '0;
  logic                 cfg_we    = 1'b0;
  logic                 cfg_index = REG_ENTRIES;
  logic [ENTRIES_W-1:0] cfg_wdata = '0;
  logic                 busy;
  logic                 out_valid;
  bks_out_t             out_data;

  sketch_mirror mirror = new();

  // Raw hashes seen recently. Reusing them is what produces count increments
  // and ties between strands, which pure random 64-bit values almost never do.
  logic [HASH_W-1:0] hash_pool[$];

  always #5 clk = ~clk;

  bottom_k_count_sketch_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Monitor. All block inputs change by nonblocking assignment at the rising
  // edge, and the block's outputs do the same, so reading them here gives the
  // values that were settled before the edge. The result is checked before
  // the new command is applied; a result never belongs to a command accepted
  // at the same edge, since even a read is answered in the following cycle.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) mirror.check_reply(out_data);
      if (start && !busy) mirror.note_item(in_data);
      if (cfg_we) mirror.write_register(cfg_index, cfg_wdata);
    end
  end

  // Safety net: the slowest legal run, roughly 800 adds plus sender gaps,
  // takes well under a tenth of this.
  initial begin
    #5_000_000;
    $display("[bottom_k_count_sketch_top] ERROR");
    $finish;
  end

  function automatic bks_in_t add_item(logic [HASH_W-1:0] fwd, logic [HASH_W-1:0] rev);
    bks_in_t item;
    item.command      = CMD_ADD;
    item.forward_hash = fwd;
    item.reverse_hash = rev;
    item.read_index   = IDX_W'($urandom);
    return item;
  endfunction

  function automatic bks_in_t read_item(logic [IDX_W-1:0] idx);
    bks_in_t item;
    item.command      = CMD_READ;
    item.forward_hash = {$urandom, $urandom};
    item.reverse_hash = {$urandom, $urandom};
    item.read_index   = idx;
    return item;
  endfunction

  // Mixes full-range values, reuse of recent ones, zero, all ones, tiny values
  // and values a small offset above a prime multiple, which reduce to tiny ones.
  function automatic logic [HASH_W-1:0] pick_hash();
    logic [HASH_W-1:0] h;
    case ($urandom_range(9))
      4, 5, 6: begin
        if (hash_pool.size() != 0) h = hash_pool[$urandom_range(hash_pool.size() - 1)];
        else h = {$urandom, $urandom};
      end
      7:       h = HASH_W'($urandom_range(4095));
      8:       h = HASH_PRIME * HASH_W'($urandom_range(1, 1000000)) + HASH_W'($urandom_range(3));
      9:       h = $urandom_range(1) ? '1 : '0;
      default: h = {$urandom, $urandom};
    endcase
    hash_pool = {hash_pool, h};
    if (hash_pool.size() > POOL_DEPTH) void'(hash_pool.pop_front());
    return h;
  endfunction

  function automatic bks_in_t random_item();
    bks_in_t item;
    item.command      = ($urandom_range(99) < READ_PCT) ? CMD_READ : CMD_ADD;
    item.forward_hash = pick_hash();
    item.reverse_hash = pick_hash();
    item.read_index   = IDX_W'($urandom_range(SKETCH_SIZE - 1));
    return item;
  endfunction

  // Offers one command and returns at the edge where it is taken. Start is
  // left high so that a following command goes out back to back; it is only
  // lowered when the sender chooses to idle or to wait for the block.
  task automatic transfer_item(input bks_in_t item, input int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (busy);
  endtask

  // Holds the sender back until the block owes nothing. The first edge is
  // skipped so the monitor has already logged the last transfer.
  task automatic wait_for_all_results();
    start <= 1'b0;
    @(posedge clk);
    while (mirror.pending() != 0 || busy) @(posedge clk);
  endtask

  // Writes both registers on consecutive edges; only ever called when idle.
  task automatic program_sketch(input logic [ENTRIES_W-1:0] entries, input logic both);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ENTRIES;
    cfg_wdata <= entries;
    @(posedge clk);
    cfg_index <= REG_BOTH;
    cfg_wdata <= ENTRIES_W'(both);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    logic [ENTRIES_W-1:0] phase_entries[6];
    logic                 phase_both[6];
    int unsigned          phase_idle[6];

    // Random phases sweep the sketch length over its extremes, including the
    // out-of-range settings of zero and above the store size.
    phase_entries = '{7'd64, 7'd8, 7'd1, 7'd127, 7'd0, ENTRIES_W'($urandom_range(2, 63))};
    phase_both    = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'($urandom_range(1))};
    phase_idle    = '{13, 13, 55, 55, 0, 0};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, full length, forward strand only. Empty slots read back
    // as all ones with count zero at both ends of the store.
    program_sketch(7'd64, 1'b0);
    transfer_item(read_item(6'd0), 0);
    transfer_item(read_item(6'd63), 0);
    // Zero inserts at the front; a repeat and the prime itself both count it.
    transfer_item(add_item('0, '1), 0);
    transfer_item(add_item('0, '1), 0);
    transfer_item(add_item(HASH_PRIME, '0), 0);
    // The largest input, a smaller value that pushes it up, then the largest residue.
    transfer_item(add_item('1, '0), 0);
    transfer_item(add_item(64'd5, '1), 0);
    transfer_item(add_item(HASH_PRIME - 1, 64'd1), 0);
    transfer_item(read_item(6'd1), 0);

    // Length one with both strands: only zero can still count, the rest are
    // discarded, and entries past the active length stay readable.
    wait_for_all_results();
    program_sketch(7'd1, 1'b1);
    transfer_item(add_item(64'd100, 64'd7), 0);
    transfer_item(add_item(64'd9, '0), 0);
    transfer_item(add_item(64'd3, 64'd9), 0);
    transfer_item(read_item(6'd2), 0);

    // A length of zero behaves as one.
    wait_for_all_results();
    program_sketch(7'd0, 1'b0);
    transfer_item(add_item(HASH_PRIME * 2, 64'd1), 0);
    transfer_item(add_item(64'd1, '0), 0);

    // A length above the store size behaves as the full store. Equal strands
    // and a smaller forward strand both take the forward value.
    wait_for_all_results();
    program_sketch(7'd127, 1'b1);
    transfer_item(add_item(64'd10, 64'd11), 0);
    transfer_item(add_item(64'd2, 64'd2), 0);
    transfer_item(add_item('1, 64'd4), 0);
    transfer_item(read_item(6'd63), 0);
    transfer_item(read_item(6'd2), 0);

    // Count saturation would need four billion repeats of one value, so it is
    // modelled in the shadow store but not reached here.

    // Random part. Every so often the sender stops until the block is drained,
    // so results also arrive with nothing in flight behind them.
    for (int p = 0; p < 6; p++) begin
      wait_for_all_results();
      program_sketch(phase_entries[p], phase_both[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        transfer_item(random_item(), phase_idle[p]);
        if ($urandom_range(39) == 0) wait_for_all_results();
      end
    end

    wait_for_all_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mirror.failures == 0) begin
      $display("[bottom_k_count_sketch_top] OK");
    end else begin
      $display("[bottom_k_count_sketch_top] ERROR");
    end
    $finish;
  end

endmodule
